// ----- hw/rtl/rmp_pkg.sv -----
// Package for the running median block: field widths, default sizes,
// operation and status codes, and the command struct sent to the cell row.
// Depends on nothing.
`default_nettype none

package rmp_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_POPPED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef struct packed {
    logic do_insert;
    logic do_pop;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rmp_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
// Depends on rmp_pkg for the field widths.
`default_nettype none

interface rmp_in_if;
  import rmp_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] value;
  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface rmp_out_if;
  import rmp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   median;
  logic [COUNT_W-1:0]  count;
  modport source (output valid, output status, output median, output count, input ready);
  modport sink   (input valid, input status, input median, input count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rmp_cell_array.sv -----
// Row of sorted value cells with parallel compare-and-shift for insert and pop,
// and a one-hot select of the lower median. Depends on rmp_pkg.
`default_nettype none

module rmp_cell_array #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = $clog2(CAPACITY + 1),
  parameter int IDX_W       = $clog2(CAPACITY)
) (
  input  wire                        clk,
  input  wire rmp_pkg::cell_cmd_t    cmd,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [IDX_W-1:0]      mid,
  input  wire logic [VALUE_WIDTH-1:0] ins_value,
  output logic [VALUE_WIDTH-1:0]     median
);
  import rmp_pkg::*;

  logic [VALUE_WIDTH-1:0] cells [CAPACITY];
  logic [CAPACITY-1:0]    sh;

  // A cell shifts up on insert when it holds a value greater than the new one.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      sh[i] = (CNT_W'(i) < count) && (cells[i] > ins_value);
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IDX_W'(i) == mid) begin
        median = median | cells[i];
      end
    end
  end

  genvar g;
  for (g = 0; g < CAPACITY; g++) begin : g_cell
    logic                   take_prev;
    logic [VALUE_WIDTH-1:0] prev_val;
    logic [VALUE_WIDTH-1:0] next_val;

    if (g == 0) begin : g_first
      assign take_prev = 1'b0;
      assign prev_val  = cells[g];
    end else begin : g_inner
      assign take_prev = sh[g-1];
      assign prev_val  = cells[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_val = cells[g];
    end else begin : g_below
      assign next_val = cells[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (take_prev) begin
          cells[g] <= prev_val;
        end else if (sh[g] || (count == CNT_W'(g))) begin
          cells[g] <= ins_value;
        end
      end else if (cmd.do_pop && (IDX_W'(g) >= mid)) begin
        cells[g] <= next_val;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rmp_ctrl.sv -----
// Operation decode and stored count: chooses the cell command, the median
// index and the result status for the item in the input register. Depends on rmp_pkg.
`default_nettype none

module rmp_ctrl #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire logic                   advance,
  input  wire logic [rmp_pkg::OP_W-1:0] operation,
  output rmp_pkg::cell_cmd_t          cmd,
  output rmp_pkg::status_t            status,
  output logic [CNT_W-1:0]            count,
  output logic [CNT_W-1:0]            count_next,
  output logic [IDX_W-1:0]            mid
);
  import rmp_pkg::*;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_new;

  assign cnt_m1 = count - CNT_W'(1);
  assign mid    = IDX_W'(cnt_m1 >> 1);

  always_comb begin
    cmd     = '0;
    status  = ST_CLEARED;
    cnt_new = '0;
    case (operation)
      OP_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          status  = ST_FULL;
          cnt_new = count;
        end else begin
          status        = ST_INSERTED;
          cmd.do_insert = advance;
          cnt_new       = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count == '0) begin
          status  = ST_EMPTY;
          cnt_new = count;
        end else begin
          status     = ST_POPPED;
          cmd.do_pop = advance;
          cnt_new    = cnt_m1;
        end
      end
      OP_CLEAR: begin
        status  = ST_CLEARED;
        cnt_new = '0;
      end
      default: begin
        status  = ST_CLEARED;
        cnt_new = '0;
      end
    endcase
  end

  assign count_next = advance ? cnt_new : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/running_median_pop.sv -----
// Running lower-median store: insert, pop lower median, clear; one result per item.
// Each item passes the input register, then the output register; it waits while results stall.
// Throughput: one item per cycle while results are not stalled, set by the parallel compare-and-shift.
// Reset clears the stored count and both register valid flags; cell contents are not cleared.
// Depends on rmp_pkg, rmp_if, rmp_ctrl and rmp_cell_array.
`default_nettype none

module running_median_pop #(
  parameter int CAPACITY    = rmp_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = rmp_pkg::VALUE_WIDTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  rmp_in_if.sink     items,
  rmp_out_if.source  results
);
  import rmp_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic                   in_valid;
  logic [OP_W-1:0]        in_op;
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   advance;
  logic                   accept;

  cell_cmd_t              cmd;
  status_t                res_status;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [IDX_W-1:0]       mid;
  logic [VALUE_WIDTH-1:0] med_sel;

  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [DATA_W-1:0]      out_median;
  logic [COUNT_W-1:0]     out_count;

  assign advance     = in_valid && (!out_valid || results.ready);
  assign items.ready = !in_valid || advance;
  assign accept      = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_op    <= items.operation;
      in_value <= VALUE_WIDTH'(items.value);
    end
  end

  rmp_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .operation  (in_op),
    .cmd        (cmd),
    .status     (res_status),
    .count      (count),
    .count_next (count_next),
    .mid        (mid)
  );

  rmp_cell_array #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_cells (
    .clk       (clk),
    .cmd       (cmd),
    .count     (count),
    .mid       (mid),
    .ins_value (in_value),
    .median    (med_sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= res_status;
      out_median <= (res_status == ST_POPPED) ? DATA_W'(med_sel) : '0;
      out_count  <= COUNT_W'(count_next);
    end
  end

  assign results.valid  = out_valid;
  assign results.status = out_status;
  assign results.median = out_median;
  assign results.count  = out_count;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_insert_count : assert property (@(posedge clk) disable iff (rst)
    (advance && res_status == ST_INSERTED) |=> count == CNT_W'($past(count) + 1'b1))
    else $error("insert did not raise the count by one");

  a_pop_count : assert property (@(posedge clk) disable iff (rst)
    (advance && res_status == ST_POPPED) |=> count == CNT_W'($past(count) - 1'b1))
    else $error("pop did not lower the count by one");

  a_hold_item : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_op) && $stable(in_value)))
    else $error("stalled item was lost from the input register");

endmodule

`default_nettype wire
